/* src/tbss_pkg.sv */
package tbss_pkg;

   // Command codes carried on the action field
   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_SINGLE = 2'd1,
      ACT_DOUBLE = 2'd2,
      ACT_SWEEP  = 2'd3
   } action_type;

   localparam int unsigned FreqW      = 16;
   localparam int unsigned DurW       = 16;
   localparam int unsigned DutyW      = 8;
   localparam int unsigned SweepW     = 11;
   localparam int unsigned SweepLen   = 1000;
   localparam int unsigned SweepHalf  = 500;
   localparam int unsigned SweepLow   = 100;
   localparam int unsigned SweepHigh  = 2000;
   localparam int unsigned SweepSpan  = SweepHigh - SweepLow;
   localparam int unsigned DutyReset  = 127;

   // Scaled step: span/half reduces to 19/5; divide by 5 as a reciprocal
   // multiply, exact for every product below 2^18
   localparam int unsigned StepNum    = 19;
   localparam int unsigned StepDen    = 5;
   localparam int unsigned RecipShift = 18;
   localparam int unsigned Recip      = ((1 << RecipShift) + StepDen - 1) / StepDen;
   localparam int unsigned ProdW      = 14;   // holds SweepHalf * StepNum
   localparam int unsigned MulW       = ProdW + 16;

   // Triangle frequency for sweep time t, valid for t up to SweepLen
   function automatic logic [FreqW-1:0] sweep_freq(input logic [SweepW-1:0] t);
      logic              rising;
      logic [9:0]        k;
      logic [ProdW-1:0]  scaled;
      logic [MulW-1:0]   prod;
      logic [11:0]       q;
      rising = (t <= SweepW'(SweepHalf));
      k      = rising ? t[9:0] : 10'(t - SweepW'(SweepHalf));
      // k * 19 as shift and add
      scaled = {k, 4'b0} + {3'b0, k, 1'b0} + {4'b0, k};
      prod   = MulW'(scaled) * MulW'(Recip);
      q      = prod[MulW-1 -: 12];
      if (rising)
         sweep_freq = FreqW'(q) + FreqW'(SweepLow);
      else
         sweep_freq = FreqW'(SweepHigh) - FreqW'(q);
   endfunction

endpackage

/* src/tone_beep_sweep_sequencer.sv */
// Buzzer tone sequencer stepped by one-millisecond ticks.
// req_ channel: one item per transfer, action selects tick, single beep,
//   double beep or sweep; freq/dur fields feed the beep commands.
// rsp_ channel: one result per item with the frequency and duty last
//   driven to the PWM generator, an updated flag and a busy flag.
// csr_ channel: writes on_duty (the duty used while a tone sounds); it
//   is always ready. It must only be written while the block is idle;
//   the block itself does not enforce this.
// A request is held in the input register; the result register loads
//   from it when the result side can advance.
// Throughput: one item per cycle while rsp_ready is high; the state
//   update per item is a single pass of counter logic plus one constant
//   multiply (sweep frequency) between the input and result registers.
// Reset: silent (frequency and duty zero), nothing running, on_duty 127.
// Stall: a result held by a low rsp_ready stays stable; one more request
//   is taken into the input register, then req_ready drops until the
//   result is taken.
module tone_beep_sweep_sequencer
   import tbss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  logic [FreqW-1:0] req_freq_a,
   input  logic [DurW-1:0]  req_dur_a,
   input  logic [FreqW-1:0] req_freq_b,
   input  logic [DurW-1:0]  req_dur_b,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [FreqW-1:0] rsp_tone_freq,
   output logic [DutyW-1:0] rsp_duty,
   output logic             rsp_updated,
   output logic             rsp_busy_res,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [DutyW-1:0] csr_on_duty
);

   // Input stage
   logic             in_valid_ff;
   logic [1:0]       act_ff;
   logic [FreqW-1:0] fa_ff;
   logic [DurW-1:0]  da_ff;
   logic [FreqW-1:0] fb_ff;
   logic [DurW-1:0]  db_ff;

   // Sequencer state
   logic              beep_ff, beep_in;
   logic              second_ff, second_in;
   logic              sweep_ff, sweep_in;
   logic [DurW-1:0]   ticks_ff, ticks_in;
   logic [FreqW-1:0]  pend_freq_ff, pend_freq_in;
   logic [DurW-1:0]   pend_dur_ff, pend_dur_in;
   logic [SweepW-1:0] sweep_t_ff, sweep_t_in;
   logic [FreqW-1:0]  cur_freq_ff, cur_freq_in;
   logic [DutyW-1:0]  cur_duty_ff, cur_duty_in;
   logic [DutyW-1:0]  on_duty_ff;

   // Result stage
   logic rsp_valid_ff;
   logic updated_ff, updated_in;

   logic advance;
   logic proc;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign proc      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         act_ff <= req_action;
         fa_ff  <= req_freq_a;
         da_ff  <= req_dur_a;
         fb_ff  <= req_freq_b;
         db_ff  <= req_dur_b;
      end
   end

   // Duty register
   always_ff @(posedge clock) begin
      if (reset) begin
         on_duty_ff <= DutyW'(DutyReset);
      end else if (csr_valid && csr_ready) begin
         on_duty_ff <= csr_on_duty;
      end
   end

   // Next state for one item
   always_comb begin
      logic [DurW-1:0]   tl_dec;
      logic [SweepW-1:0] t_inc;
      beep_in      = beep_ff;
      second_in    = second_ff;
      sweep_in     = sweep_ff;
      ticks_in     = ticks_ff;
      pend_freq_in = pend_freq_ff;
      pend_dur_in  = pend_dur_ff;
      sweep_t_in   = sweep_t_ff;
      cur_freq_in  = cur_freq_ff;
      cur_duty_in  = cur_duty_ff;
      updated_in   = 1'b0;
      tl_dec = (ticks_ff != '0) ? ticks_ff - 1'b1 : ticks_ff;
      t_inc  = (sweep_t_ff != '1) ? sweep_t_ff + 1'b1 : sweep_t_ff;
      case (action_type'(act_ff))
         ACT_SINGLE: begin
            sweep_in    = 1'b0;
            second_in   = 1'b0;
            cur_freq_in = fa_ff;
            cur_duty_in = on_duty_ff;
            ticks_in    = da_ff;
            beep_in     = 1'b1;
            updated_in  = 1'b1;
         end
         ACT_DOUBLE: begin
            sweep_in     = 1'b0;
            second_in    = 1'b1;
            pend_freq_in = fb_ff;
            pend_dur_in  = db_ff;
            cur_freq_in  = fa_ff;
            cur_duty_in  = on_duty_ff;
            ticks_in     = da_ff;
            beep_in      = 1'b1;
            updated_in   = 1'b1;
         end
         ACT_SWEEP: begin
            sweep_in   = 1'b1;
            beep_in    = 1'b0;
            second_in  = 1'b0;
            sweep_t_in = '0;
         end
         ACT_TICK: begin
            // beep countdown: decrement first, then check expiry
            if (beep_ff) begin
               ticks_in = tl_dec;
               if (tl_dec == '0) begin
                  if (second_ff) begin
                     cur_freq_in = pend_freq_ff;
                     cur_duty_in = on_duty_ff;
                     ticks_in    = pend_dur_ff;
                     second_in   = 1'b0;
                  end else begin
                     cur_freq_in = '0;
                     cur_duty_in = '0;
                     beep_in     = 1'b0;
                  end
                  updated_in = 1'b1;
               end
            end
            // sweep step
            if (sweep_ff) begin
               sweep_t_in = t_inc;
               if (t_inc <= SweepW'(SweepLen)) begin
                  cur_freq_in = sweep_freq(t_inc);
                  cur_duty_in = on_duty_ff;
               end else begin
                  sweep_in    = 1'b0;
                  cur_freq_in = '0;
                  cur_duty_in = '0;
               end
               updated_in = 1'b1;
            end
         end
         default: begin
            updated_in = 1'b0;
         end
      endcase
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         beep_ff      <= 1'b0;
         second_ff    <= 1'b0;
         sweep_ff     <= 1'b0;
         ticks_ff     <= '0;
         sweep_t_ff   <= '0;
         cur_freq_ff  <= '0;
         cur_duty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         updated_ff   <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (proc) begin
            beep_ff     <= beep_in;
            second_ff   <= second_in;
            sweep_ff    <= sweep_in;
            ticks_ff    <= ticks_in;
            sweep_t_ff  <= sweep_t_in;
            cur_freq_ff <= cur_freq_in;
            cur_duty_ff <= cur_duty_in;
            updated_ff  <= updated_in;
         end
      end
      if (proc) begin
         pend_freq_ff <= pend_freq_in;
         pend_dur_ff  <= pend_dur_in;
      end
   end

   // Current tone registers double as the result payload
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tone_freq = cur_freq_ff;
   assign rsp_duty      = cur_duty_ff;
   assign rsp_updated   = updated_ff;
   assign rsp_busy_res  = beep_ff || sweep_ff;

`ifndef ASSERT_OFF
   // beep and sweep never run together
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(beep_ff && sweep_ff))
      else $error("beep and sweep both running");

   // a pending second beep only exists inside a running beep
   a_second_in_beep: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> beep_ff)
      else $error("second beep pending without a beep");

   // a tone that just ended leaves the output silent
   a_end_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_updated && !rsp_busy_res)
         |-> (rsp_tone_freq == '0 && rsp_duty == '0))
      else $error("tone ended without silence");

   // sweep time never passes one step beyond the triangle
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      sweep_t_ff <= SweepW'(SweepLen + 1))
      else $error("sweep time out of range");
`endif

endmodule

/* bench/testbench.sv */
module testbench;
   import tbss_pkg::*;

   // One request item and one result item, as carried on the ports
   typedef struct packed {
      action_type       action;
      logic [FreqW-1:0] freq_a;
      logic [DurW-1:0]  dur_a;
      logic [FreqW-1:0] freq_b;
      logic [DurW-1:0]  dur_b;
   } tone_req_type;

   typedef struct packed {
      logic [FreqW-1:0] tone_freq;
      logic [DutyW-1:0] duty;
      logic             updated;
      logic             busy;
   } tone_rsp_type;

   // Directed row: a request and, where it is obvious, the result typed in
   typedef struct {
      tone_req_type req;
      bit           typed;
      tone_rsp_type want;
   } tone_row_type;

   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 80;
   localparam int BurstItems = 180;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_action = ACT_TICK;
   logic [FreqW-1:0] req_freq_a = '0;
   logic [DurW-1:0]  req_dur_a = '0;
   logic [FreqW-1:0] req_freq_b = '0;
   logic [DurW-1:0]  req_dur_b = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [FreqW-1:0] rsp_tone_freq;
   logic [DutyW-1:0] rsp_duty;
   logic             rsp_updated;
   logic             rsp_busy_res;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [DutyW-1:0] csr_on_duty = '0;

   tone_beep_sweep_sequencer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_freq_a    (req_freq_a),
      .req_dur_a     (req_dur_a),
      .req_freq_b    (req_freq_b),
      .req_dur_b     (req_dur_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tone_freq (rsp_tone_freq),
      .rsp_duty      (rsp_duty),
      .rsp_updated   (rsp_updated),
      .rsp_busy_res  (rsp_busy_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_on_duty   (csr_on_duty)
   );

   always #6 clock = ~clock;

   // Sequencer state as the bench sees it
   logic [DutyW-1:0]  duty_setting = DutyW'(DutyReset);
   logic              beep_on = 1'b0;
   logic              second_armed = 1'b0;
   logic              sweep_on = 1'b0;
   logic [DurW-1:0]   beep_left = '0;
   logic [FreqW-1:0]  second_freq = '0;
   logic [DurW-1:0]   second_dur = '0;
   logic [SweepW-1:0] sweep_age = '0;
   logic [FreqW-1:0]  tone_now = '0;
   logic [DutyW-1:0]  duty_now = '0;

   tone_rsp_type pending_tones[$];

   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int phase_no = 0;
   int items_sent = 0;
   int results_seen = 0;
   int tone_writes = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int hold_count = 0;
   bit hold_done = 1'b0;

   // Directed opening: zero and full-scale fields, every command, cancels,
   // zero-length beeps and the first steps of a sweep (on_duty at reset)
   tone_row_type directed_rows [23] = '{
      '{'{ACT_TICK,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{16'h0000, 8'd0,   1'b0, 1'b0}},
      '{'{ACT_SINGLE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{16'hFFFF, 8'd127, 1'b1, 1'b1}},
      '{'{ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
        '{16'h0000, 8'd0,   1'b1, 1'b0}},
      '{'{ACT_TICK,   16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1,
        '{16'h0000, 8'd0,   1'b0, 1'b0}},
      '{'{ACT_SINGLE, 16'h0000, 16'h0002, 16'h1111, 16'h2222}, 1'b1,
        '{16'h0000, 8'd127, 1'b1, 1'b1}},
      '{'{ACT_TICK,   16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0},
      '{'{ACT_TICK,   16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, '0},
      '{'{ACT_DOUBLE, 16'h1234, 16'h0001, 16'hFFFF, 16'h0000}, 1'b1,
        '{16'h1234, 8'd127, 1'b1, 1'b1}},
      '{'{ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{ACT_DOUBLE, 16'hAAAA, 16'hFFFF, 16'h5555, 16'hFFFF}, 1'b1,
        '{16'hAAAA, 8'd127, 1'b1, 1'b1}},
      '{'{ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{ACT_SWEEP,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{ACT_TICK,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{ACT_SINGLE, 16'h8001, 16'hFFFF, 16'h0000, 16'h0000}, 1'b1,
        '{16'h8001, 8'd127, 1'b1, 1'b1}},
      '{'{ACT_SWEEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{ACT_DOUBLE, 16'h7FFE, 16'h0000, 16'h0001, 16'h0001}, 1'b0, '0},
      '{'{ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{ACT_SWEEP,  16'h5555, 16'h5555, 16'h5555, 16'h5555}, 1'b0, '0},
      '{'{ACT_TICK,   16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA}, 1'b0, '0}
   };

   // Advance the sequencer by one request and return the result it gives
   function automatic tone_rsp_type advance_tone(input tone_req_type r);
      tone_rsp_type res;
      int unsigned  age;
      res = '0;
      case (r.action)
         ACT_SINGLE, ACT_DOUBLE: begin
            sweep_on     = 1'b0;
            second_armed = (r.action == ACT_DOUBLE);
            if (r.action == ACT_DOUBLE) begin
               second_freq = r.freq_b;
               second_dur  = r.dur_b;
            end
            tone_now    = r.freq_a;
            duty_now    = duty_setting;
            beep_left   = r.dur_a;
            beep_on     = 1'b1;
            res.updated = 1'b1;
         end
         ACT_SWEEP: begin
            sweep_on     = 1'b1;
            beep_on      = 1'b0;
            second_armed = 1'b0;
            sweep_age    = '0;
         end
         default: begin
            // countdown saturates at zero, expiry checked after the step
            if (beep_on) begin
               if (beep_left != 0)
                  beep_left = beep_left - 1'b1;
               if (beep_left == 0) begin
                  if (second_armed) begin
                     tone_now     = second_freq;
                     duty_now     = duty_setting;
                     beep_left    = second_dur;
                     second_armed = 1'b0;
                  end else begin
                     tone_now = '0;
                     duty_now = '0;
                     beep_on  = 1'b0;
                  end
                  res.updated = 1'b1;
               end
            end
            // triangle: up from the low end to the top, then back down
            if (sweep_on) begin
               if (sweep_age != '1)
                  sweep_age = sweep_age + 1'b1;
               age = sweep_age;
               if (age <= SweepLen) begin
                  if (age <= SweepHalf)
                     tone_now = FreqW'(age * SweepSpan / SweepHalf + SweepLow);
                  else
                     tone_now = FreqW'(SweepHigh - (age - SweepHalf) * SweepSpan / SweepHalf);
                  duty_now = duty_setting;
               end else begin
                  sweep_on = 1'b0;
                  tone_now = '0;
                  duty_now = '0;
               end
               res.updated = 1'b1;
            end
         end
      endcase
      res.tone_freq = tone_now;
      res.duty      = duty_now;
      res.busy      = beep_on | sweep_on;
      return res;
   endfunction

   function automatic tone_req_type any_req(input action_type a);
      tone_req_type r;
      r.action = a;
      r.freq_a = FreqW'($urandom);
      r.dur_a  = DurW'($urandom);
      r.freq_b = FreqW'($urandom);
      r.dur_b  = DurW'($urandom);
      return r;
   endfunction

   // Offer one request and record its result once the transfer happens
   task automatic offer(input tone_req_type r, input bit typed, input tone_rsp_type want);
      tone_rsp_type predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= r.action;
      req_freq_a <= r.freq_a;
      req_dur_a  <= r.dur_a;
      req_freq_b <= r.freq_b;
      req_dur_b  <= r.dur_b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = advance_tone(r);
      pending_tones.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Stop offering and let every outstanding result come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_tones.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_on_duty(input logic [DutyW-1:0] level);
      settle();
      csr_valid   <= 1'b1;
      csr_on_duty <= level;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid    <= 1'b0;
      duty_setting = level;
   endtask

   // One random sequence: mostly beeps or sweeps followed by the ticks that
   // play them out, with some noise and idle ticks mixed in
   task automatic random_sequence();
      tone_req_type r;
      int           pick;
      int           ticks;
      pick  = $urandom_range(0, 99);
      ticks = 0;
      if (pick < 55) begin
         r = any_req(pick < 30 ? ACT_SINGLE : ACT_DOUBLE);
         if ($urandom_range(0, 7) != 0) begin
            r.dur_a = DurW'($urandom_range(0, 6));
            r.dur_b = DurW'($urandom_range(0, 6));
         end
         ticks = r.dur_a + 1 + $urandom_range(0, 2);
         if (r.action == ACT_DOUBLE)
            ticks += r.dur_b + 1;
         // sometimes cut short by the next command
         if ($urandom_range(0, 4) == 0)
            ticks = $urandom_range(0, ticks);
         if (ticks > 16)
            ticks = 16;
         offer(r, 1'b0, '0);
      end else if (pick < 70) begin
         offer(any_req(ACT_SWEEP), 1'b0, '0);
         ticks = $urandom_range(1, 30);
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 3))
            offer(any_req(action_type'($urandom_range(0, 3))), 1'b0, '0);
      end else begin
         ticks = $urandom_range(1, 4);
      end
      repeat (ticks)
         offer(any_req(ACT_TICK), 1'b0, '0);
   endtask

   // Result side: random stalls, plus one long hold-off in the stall phase
   always @(posedge clock) begin
      if (phase_no == 2 && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HoldCycles - 1)
            hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare each result transfer with the oldest outstanding prediction
   always @(posedge clock) begin : check_results
      tone_rsp_type got;
      tone_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_tone_freq, rsp_duty, rsp_updated, rsp_busy_res};
         results_seen++;
         if (got.updated)
            tone_writes++;
         if (pending_tones.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with no request outstanding: %h %h upd %b busy %b",
                        got.tone_freq, got.duty, got.updated, got.busy);
         end else begin
            want = pending_tones.pop_front();
            if (got.tone_freq !== want.tone_freq || got.duty !== want.duty ||
                got.updated !== want.updated || got.busy !== want.busy) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: freq %h/%h duty %h/%h upd %b/%b busy %b/%b",
                           results_seen, want.tone_freq, got.tone_freq, want.duty,
                           got.duty, want.updated, got.updated, want.busy, got.busy);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_tones.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int                target;
      logic [DutyW-1:0]  mid_duty;
      mid_duty = DutyW'($urandom_range(1, 254));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < 4; ph++) begin
         // on_duty stays at its reset value for the first phase
         case (ph)
            1: write_on_duty('0);
            2: write_on_duty('1);
            3: write_on_duty(mid_duty);
            default: ;
         endcase
         phase_no = ph;
         case (ph)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
            default: begin send_gap_pct = 30; recv_stall_pct = 30; end
         endcase
         if (ph == 0) begin
            foreach (directed_rows[i])
               offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            // one sweep played out to the end and a little beyond
            offer(any_req(ACT_SWEEP), 1'b0, '0);
            repeat (SweepLen + 3)
               offer(any_req(ACT_TICK), 1'b0, '0);
         end
         target = items_sent + BurstItems;
         while (items_sent < target)
            random_sequence();
      end

      settle();
      repeat (4) @(posedge clock);
      $display("%0d requests, %0d results checked (%0d tone writes), one full sweep;",
               items_sent, results_seen, tone_writes);
      $display("free-running, gapped, stalled and mixed traffic, on_duty 127/0/255/%0d",
               mid_duty);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
src/tbss_pkg.sv
src/tone_beep_sweep_sequencer.sv
bench/testbench.sv
